[rtl/ptfe_pkg.sv]
// shared types, constants and the crc step for the telemetry frame encoder
// no dependencies; every other rtl file refers to this package by scoped names
package ptfe_pkg;

  localparam int unsigned IN_W       = 272;
  localparam int unsigned LANES      = 6;
  localparam int unsigned FRAME_LEN  = 31;
  localparam int unsigned CRC_BYTES  = 29;
  localparam int unsigned Q_DEPTH    = 2;
  localparam logic [7:0]  BODY_LEN   = 8'd24;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [9:0]  SCALE      = 10'd1000;
  localparam logic [41:0] ROUND_HALF = 42'd32768;
  localparam logic [31:0] INTERVAL_RST = 32'd100;

  // scaled lanes
  localparam int unsigned LN_LEFT  = 0;
  localparam int unsigned LN_RIGHT = 1;
  localparam int unsigned LN_X     = 2;
  localparam int unsigned LN_Y     = 3;
  localparam int unsigned LN_HEAD  = 4;
  localparam int unsigned LN_BATT  = 5;

  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_FRAME_KIND  = 2'd2,
    REG_INTERVAL    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  frame_kind;
    logic [31:0] send_interval;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  fault;
    logic [7:0]  level;
    logic [15:0] batt_mv;
    logic [31:0] head;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
    logic [15:0] right_spd;
    logic [15:0] left_spd;
    logic [31:0] stamp;
    logic [7:0]  seq;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // one byte of crc-16/ccitt-false, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/ptfe_front.sv]
// front part: accepts samples, applies the send interval, scales fields into a frame record
// depends on ptfe_pkg; feeds ptfe_queue
module ptfe_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ptfe_pkg::cfg_t               cfg,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [ptfe_pkg::IN_W-1:0]    in_tdata,
  input  ptfe_pkg::q_stat_t            q_stat,
  output logic                         push,
  output ptfe_pkg::frame_rec_t         push_rec
);

  // stage 1: input register
  logic                      s1_v_r, s1_v_nxt;
  logic [ptfe_pkg::IN_W-1:0] s1_data_r;
  logic [31:0]               last_send_r;
  logic [7:0]                seq_r;

  // stage 2: magnitudes
  logic        s2_v_r, s2_v_nxt;
  logic [31:0] s2_mag_r [ptfe_pkg::LANES];
  logic [ptfe_pkg::LANES-1:0] s2_neg_r;
  logic        s2_bzero_r;
  logic [31:0] s2_stamp_r;
  logic [7:0]  s2_level_r, s2_fault_r, s2_seq_r;

  // stage 3: products
  logic        s3_v_r, s3_v_nxt;
  logic [41:0] s3_prod_r [ptfe_pkg::LANES];
  logic [ptfe_pkg::LANES-1:0] s3_neg_r;
  logic        s3_bzero_r;
  logic [31:0] s3_stamp_r;
  logic [7:0]  s3_level_r, s3_fault_r, s3_seq_r;

  logic        s1_emit, s1_go, s2_ready, s3_ready;
  logic [31:0] now, elapsed;
  logic [31:0] raw [ptfe_pkg::LANES];
  logic [31:0] mag [ptfe_pkg::LANES];
  logic [25:0] rnd [ptfe_pkg::LANES];
  logic [31:0] wide [ptfe_pkg::LANES];
  logic [15:0] spd [2];

  assign now     = s1_data_r[31:0];
  assign elapsed = now - last_send_r;
  assign s1_emit = elapsed >= cfg.send_interval;

  assign s3_ready  = !s3_v_r || !q_stat.full;
  assign s2_ready  = !s2_v_r || s3_ready;
  assign s1_go     = s1_v_r && (!s1_emit || s2_ready);
  assign in_tready = !s1_v_r || s1_go;

  always_comb begin
    for (int i = 0; i < ptfe_pkg::LANES; i++) begin
      raw[i] = s1_data_r[64 + 32*i +: 32];
      mag[i] = raw[i][31] ? (~raw[i] + 32'd1) : raw[i];
    end
  end

  assign s1_v_nxt = (in_tvalid && in_tready) ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
  assign s2_v_nxt = (s1_go && s1_emit) ? 1'b1 : ((s2_v_r && s3_ready) ? 1'b0 : s2_v_r);
  assign s3_v_nxt = (s2_v_r && s3_ready) ? 1'b1 : ((s3_v_r && !q_stat.full) ? 1'b0 : s3_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      last_send_r <= '0;
      seq_r       <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
      if (s1_go && s1_emit) begin
        last_send_r <= now;
        seq_r       <= seq_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata;
    end
    if (s1_go && s1_emit) begin
      for (int i = 0; i < ptfe_pkg::LANES; i++) begin
        s2_mag_r[i] <= mag[i];
        s2_neg_r[i] <= raw[i][31];
      end
      s2_bzero_r <= (raw[ptfe_pkg::LN_BATT] == 32'd0) || raw[ptfe_pkg::LN_BATT][31];
      s2_stamp_r <= s1_data_r[63:32];
      s2_level_r <= s1_data_r[263:256];
      s2_fault_r <= s1_data_r[271:264];
      s2_seq_r   <= seq_r;
    end
    if (s2_v_r && s3_ready) begin
      for (int i = 0; i < ptfe_pkg::LANES; i++) begin
        s3_prod_r[i] <= {10'd0, s2_mag_r[i]} * {32'd0, ptfe_pkg::SCALE};
      end
      s3_neg_r   <= s2_neg_r;
      s3_bzero_r <= s2_bzero_r;
      s3_stamp_r <= s2_stamp_r;
      s3_level_r <= s2_level_r;
      s3_fault_r <= s2_fault_r;
      s3_seq_r   <= s2_seq_r;
    end
  end

  // round half away from zero on the magnitude, then restore sign and saturate
  always_comb begin
    for (int i = 0; i < ptfe_pkg::LANES; i++) begin
      rnd[i]  = 26'((s3_prod_r[i] + ptfe_pkg::ROUND_HALF) >> 16);
      wide[i] = s3_neg_r[i] ? (32'd0 - {6'd0, rnd[i]}) : {6'd0, rnd[i]};
    end
    for (int i = 0; i < 2; i++) begin
      if (s3_neg_r[i]) begin
        spd[i] = (rnd[i] > 26'd32768) ? 16'h8000 : (16'd0 - rnd[i][15:0]);
      end else begin
        spd[i] = (rnd[i] > 26'd32767) ? 16'h7FFF : rnd[i][15:0];
      end
    end
  end

  always_comb begin
    push_rec.seq       = s3_seq_r;
    push_rec.stamp     = s3_stamp_r;
    push_rec.left_spd  = spd[ptfe_pkg::LN_LEFT];
    push_rec.right_spd = spd[ptfe_pkg::LN_RIGHT];
    push_rec.pos_x     = wide[ptfe_pkg::LN_X];
    push_rec.pos_y     = wide[ptfe_pkg::LN_Y];
    push_rec.head      = wide[ptfe_pkg::LN_HEAD];
    if (s3_bzero_r) begin
      push_rec.batt_mv = 16'd0;
    end else if (rnd[ptfe_pkg::LN_BATT] > 26'd65535) begin
      push_rec.batt_mv = 16'hFFFF;
    end else begin
      push_rec.batt_mv = rnd[ptfe_pkg::LN_BATT][15:0];
    end
    push_rec.level = s3_level_r;
    push_rec.fault = s3_fault_r;
  end

  assign push = s3_v_r && !q_stat.full;

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("push into full queue");
  a_send_time: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_emit) |=> (last_send_r == $past(now)) && s2_v_r)
    else $error("send time not taken on emitted sample");
  a_hold_s3: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && q_stat.full) |=> s3_v_r && $stable(s3_seq_r))
    else $error("stage 3 lost a record while queue full");

endmodule

[rtl/ptfe_queue.sv]
// short record queue between front and back parts
// depends on ptfe_pkg for the record and status types
module ptfe_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ptfe_pkg::frame_rec_t push_rec,
  input  logic                 pop,
  output ptfe_pkg::frame_rec_t head,
  output ptfe_pkg::q_stat_t    q_stat
);

  localparam int unsigned PW = (ptfe_pkg::Q_DEPTH > 1) ? $clog2(ptfe_pkg::Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(ptfe_pkg::Q_DEPTH + 1);

  ptfe_pkg::frame_rec_t slot_r [ptfe_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(ptfe_pkg::Q_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = count_r == CW'(ptfe_pkg::Q_DEPTH);
  assign q_stat.empty = count_r == '0;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

[rtl/ptfe_back.sv]
// back part: serializes the head record into frame bytes with a running crc
// depends on ptfe_pkg; reads ptfe_queue, drives the output register
module ptfe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptfe_pkg::cfg_t       cfg,
  input  ptfe_pkg::frame_rec_t head,
  input  ptfe_pkg::q_stat_t    q_stat,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);

  localparam logic [4:0] LAST_IDX = 5'(ptfe_pkg::FRAME_LEN - 1);
  localparam logic [4:0] CRC_IDX  = 5'(ptfe_pkg::CRC_BYTES);

  logic [4:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        vld_r, vld_nxt;
  logic [7:0]  byte_r;
  logic        last_r;
  logic        load, emit, at_last;
  logic [8*ptfe_pkg::FRAME_LEN-1:0] frame_vec;
  logic [7:0]  cur_byte;

  assign frame_vec = {crc_r, head.fault, head.level, head.batt_mv, head.head, head.pos_y,
                      head.pos_x, head.right_spd, head.left_spd, head.stamp, head.seq,
                      ptfe_pkg::BODY_LEN, cfg.frame_kind, cfg.sync_second,
                      cfg.sync_first};
  assign cur_byte  = frame_vec[{idx_r, 3'b000} +: 8];

  assign load    = !vld_r || out_tready;
  assign emit    = load && !q_stat.empty;
  assign at_last = idx_r == LAST_IDX;
  assign pop     = emit && at_last;

  always_comb begin
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    vld_nxt = vld_r;
    if (emit) begin
      vld_nxt = 1'b1;
      if (at_last) begin
        idx_nxt = '0;
        crc_nxt = ptfe_pkg::CRC_INIT;
      end else begin
        idx_nxt = idx_r + 5'd1;
        if (idx_r < CRC_IDX) begin
          crc_nxt = ptfe_pkg::crc_byte(crc_r, cur_byte);
        end
      end
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      crc_r <= ptfe_pkg::CRC_INIT;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= cur_byte;
      last_r <= at_last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("pop from empty queue");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_IDX) else $error("byte index past frame end");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !out_tready) |=> $stable(idx_r) && $stable(crc_r))
    else $error("serializer advanced while output stalled");
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && at_last) |=> (idx_r == '0) && (crc_r == ptfe_pkg::CRC_INIT))
    else $error("frame end did not restart index and crc");

endmodule

[rtl/periodic_telemetry_frame_encoder.sv]
// periodic telemetry frame encoder, top level: config registers, front, queue, back
// depends on ptfe_pkg, ptfe_front, ptfe_queue, ptfe_back
//
// usage: each word on in_* carries a present time and one telemetry sample. when
// the time since the last sent frame (mod 2^32) reaches send_interval, a 31-byte
// frame leaves on out_*, one byte per word, out_tlast on the final crc byte;
// otherwise the sample is dropped and nothing is sent.
// path: a sending sample passes the input register, the magnitude stage, the
// multiply by 1000, round/saturate into the queue, then the output byte register.
// throughput: samples are taken one per cycle through the three front stages
// and a two-record queue while no stage is stalled; the byte serializer sets the
// sustained rate, one frame byte per cycle while out_tready is high. dropped
// samples leave from the input register and never enter stage 2.
// reset (rst_n low, synchronous): sync bytes and kind clear, send_interval
// becomes 100, last send time and frame counter clear, queue empties.
// when out_tready is low the current byte holds; the front keeps accepting
// until its stages and the queue are full, then drops in_tready.
// config registers (apb, byte addresses): 0x0 sync_first, 0x4 sync_second,
// 0x8 frame_kind, 0xc send_interval; write only while the block is idle.
module periodic_telemetry_frame_encoder (
  input  logic                      clk,
  input  logic                      rst_n,
  // current_time, sample_time, left_speed, right_speed, pos_x, pos_y, heading,
  // battery_volts, battery_level, fault_bits (lowest bit up)
  input  logic [ptfe_pkg::IN_W-1:0] in_tdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // frame_byte
  output logic [7:0]                out_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic                      out_tlast,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [3:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  ptfe_pkg::cfg_t       cfg_r;
  ptfe_pkg::reg_idx_t   reg_idx;
  ptfe_pkg::frame_rec_t push_rec, head;
  ptfe_pkg::q_stat_t    q_stat;
  logic                 push, pop, wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = ptfe_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first    <= '0;
      cfg_r.sync_second   <= '0;
      cfg_r.frame_kind    <= '0;
      cfg_r.send_interval <= ptfe_pkg::INTERVAL_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        ptfe_pkg::REG_SYNC_FIRST:  cfg_r.sync_first    <= cfg_pwdata[7:0];
        ptfe_pkg::REG_SYNC_SECOND: cfg_r.sync_second   <= cfg_pwdata[7:0];
        ptfe_pkg::REG_FRAME_KIND:  cfg_r.frame_kind    <= cfg_pwdata[7:0];
        ptfe_pkg::REG_INTERVAL:    cfg_r.send_interval <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ptfe_pkg::REG_SYNC_FIRST:  cfg_prdata = {24'd0, cfg_r.sync_first};
      ptfe_pkg::REG_SYNC_SECOND: cfg_prdata = {24'd0, cfg_r.sync_second};
      ptfe_pkg::REG_FRAME_KIND:  cfg_prdata = {24'd0, cfg_r.frame_kind};
      ptfe_pkg::REG_INTERVAL:    cfg_prdata = cfg_r.send_interval;
      default:                   cfg_prdata = '0;
    endcase
  end

  ptfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_rec  (push_rec)
  );

  ptfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  ptfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
